@@ design/esc_pkg.sv @@
// ----------------------------------------------------------------------------
// Environmental sensor compensation package
// Shared item types, coefficient bundle, register indexes and queue sizing.
// ----------------------------------------------------------------------------
package esc_pkg;

  // Configuration port sizing.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM_A   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM_B   = 3'd5;

  // Item queue between the front and the back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // One raw reading.
  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } in_item_t;

  // One compensated result.
  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic [16:0]        humidity_q22_10;
    logic               pressure_invalid;
  } out_item_t;

  // Calibration coefficients, split out of the configuration registers.
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [15:0] h4;
    logic [15:0] h5;
    logic [7:0]  h6;
  } coeff_t;

endpackage

@@ design/esc_fifo.sv @@
// ----------------------------------------------------------------------------
// Item queue
// Small register queue that lets the front and the back stall on their own.
// ----------------------------------------------------------------------------
module esc_fifo
  import esc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_valid_i,
  output logic     wr_ready_o,
  input  in_item_t wr_data_i,
  output logic     rd_valid_o,
  input  logic     rd_ready_i,
  output in_item_t rd_data_o
);

  in_item_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]     cnt_q;
  logic                push, pop;

  assign wr_ready_o = (cnt_q != (QPTR_W+1)'(QDEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      if (push && !pop)      cnt_q <= cnt_q + (QPTR_W+1)'(1);
      else if (pop && !push) cnt_q <= cnt_q - (QPTR_W+1)'(1);
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= wr_data_i;
  end

  // The fill count never exceeds the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPTR_W+1)'(QDEPTH))
    else $error("queue fill count above depth");

  // A lone push raises the fill count by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + (QPTR_W+1)'(1))
    else $error("queue count did not follow a push");

endmodule

@@ design/esc_front.sv @@
// ----------------------------------------------------------------------------
// Front end
// Holds the calibration registers, splits them into coefficients and passes
// accepted items into the queue.
// ----------------------------------------------------------------------------
module esc_front
  import esc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  q_valid_o,
  input  logic                  q_ready_i,
  output in_item_t              q_data_o,
  output coeff_t                coeff_o
);

  logic [47:0] temp_q, press_a_q, press_b_q, press_c_q;
  logic [31:0] hum_a_q;
  logic [39:0] hum_b_q;

  assign cfg_ready_o = 1'b1;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q    <= '0;
      press_a_q <= '0;
      press_b_q <= '0;
      press_c_q <= '0;
      hum_a_q   <= '0;
      hum_b_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TEMP:    temp_q    <= cfg_data_i;
        CFG_PRESS_A: press_a_q <= cfg_data_i;
        CFG_PRESS_B: press_b_q <= cfg_data_i;
        CFG_PRESS_C: press_c_q <= cfg_data_i;
        CFG_HUM_A:   hum_a_q   <= cfg_data_i[31:0];
        CFG_HUM_B:   hum_b_q   <= cfg_data_i[39:0];
        default: ;
      endcase
    end
  end

  // Coefficient fields.
  always_comb begin
    coeff_o.t1 = temp_q[15:0];
    coeff_o.t2 = temp_q[31:16];
    coeff_o.t3 = temp_q[47:32];
    coeff_o.p1 = press_a_q[15:0];
    coeff_o.p2 = press_a_q[31:16];
    coeff_o.p3 = press_a_q[47:32];
    coeff_o.p4 = press_b_q[15:0];
    coeff_o.p5 = press_b_q[31:16];
    coeff_o.p6 = press_b_q[47:32];
    coeff_o.p7 = press_c_q[15:0];
    coeff_o.p8 = press_c_q[31:16];
    coeff_o.p9 = press_c_q[47:32];
    coeff_o.h1 = hum_a_q[7:0];
    coeff_o.h2 = hum_a_q[23:8];
    coeff_o.h3 = hum_a_q[31:24];
    coeff_o.h4 = hum_b_q[15:0];
    coeff_o.h5 = hum_b_q[31:16];
    coeff_o.h6 = hum_b_q[39:32];
  end

  // Queue feeding.
  esc_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (in_valid_i),
    .wr_ready_o (in_ready_o),
    .wr_data_i  (in_data_i),
    .rd_valid_o (q_valid_o),
    .rd_ready_i (q_ready_i),
    .rd_data_o  (q_data_o)
  );

endmodule

@@ design/esc_mul.sv @@
// ----------------------------------------------------------------------------
// Shared multiplier
// Low 64 bits of a 64 x 64 product from one 32 x 32 multiplier.
// ----------------------------------------------------------------------------
module esc_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] res_o
);

  logic [63:0] a_q, b_q, acc_q, prod;
  logic [31:0] mx_a, mx_b;
  logic [1:0]  ph_q;
  logic        busy_q, done_q;

  // Partial product select: low x low, then the two cross terms.
  always_comb begin
    case (ph_q)
      2'd0:    begin mx_a = a_q[31:0];  mx_b = b_q[31:0];  end
      2'd1:    begin mx_a = a_q[31:0];  mx_b = b_q[63:32]; end
      default: begin mx_a = a_q[63:32]; mx_b = b_q[31:0];  end
    endcase
    prod = {32'b0, mx_a} * {32'b0, mx_b};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        ph_q   <= '0;
      end else if (busy_q) begin
        ph_q <= ph_q + 2'd1;
        if (ph_q == 2'd2) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operands and accumulator.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      if (ph_q == 2'd0) acc_q <= prod;
      else              acc_q <= acc_q + {prod[31:0], 32'b0};
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

@@ design/esc_div.sv @@
// ----------------------------------------------------------------------------
// Signed divider
// 64-bit signed division, truncating toward zero, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module esc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic [63:0] rem_q, quo_q, den_q, rem_sh, res_q;
  logic [5:0]  cnt_q;
  logic        busy_q, fin_q, done_q, neg_q, fit;

  // Restoring step.
  assign rem_sh = {rem_q[62:0], quo_q[63]};
  assign fit    = (rem_sh >= den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        done_q <= 1'b1;
      end
    end
  end

  // Magnitudes in, sign restored at the end.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[63] ^ den_i[63];
      quo_q <= num_i[63] ? (64'd0 - num_i) : num_i;
      den_q <= den_i[63] ? (64'd0 - den_i) : den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fit ? (rem_sh - den_q) : rem_sh;
      quo_q <= {quo_q[62:0], fit};
    end else if (fin_q) begin
      res_q <= neg_q ? (64'd0 - quo_q) : quo_q;
    end
  end

  assign done_o = done_q;
  assign quo_o  = res_q;

endmodule

@@ design/esc_back.sv @@
// ----------------------------------------------------------------------------
// Back end
// Sequencer that runs the temperature, pressure and humidity compensation on
// a shared multiplier and divider, and holds the result register.
// ----------------------------------------------------------------------------
module esc_back
  import esc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  output logic      q_ready_o,
  input  in_item_t  q_data_i,
  input  coeff_t    coeff_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_T0   = 5'd1;
  localparam logic [4:0] ST_T1   = 5'd2;
  localparam logic [4:0] ST_T2   = 5'd3;
  localparam logic [4:0] ST_T3   = 5'd4;
  localparam logic [4:0] ST_P0   = 5'd5;
  localparam logic [4:0] ST_P1   = 5'd6;
  localparam logic [4:0] ST_P2   = 5'd7;
  localparam logic [4:0] ST_P3   = 5'd8;
  localparam logic [4:0] ST_P4   = 5'd9;
  localparam logic [4:0] ST_P5   = 5'd10;
  localparam logic [4:0] ST_P6   = 5'd11;
  localparam logic [4:0] ST_P7   = 5'd12;
  localparam logic [4:0] ST_P8   = 5'd13;
  localparam logic [4:0] ST_P9   = 5'd14;
  localparam logic [4:0] ST_P10  = 5'd15;
  localparam logic [4:0] ST_P11  = 5'd16;
  localparam logic [4:0] ST_P12  = 5'd17;
  localparam logic [4:0] ST_H0   = 5'd18;
  localparam logic [4:0] ST_H1   = 5'd19;
  localparam logic [4:0] ST_H2   = 5'd20;
  localparam logic [4:0] ST_H3   = 5'd21;
  localparam logic [4:0] ST_H4   = 5'd22;
  localparam logic [4:0] ST_H5   = 5'd23;
  localparam logic [4:0] ST_H6   = 5'd24;
  localparam logic [4:0] ST_H7   = 5'd25;
  localparam logic [4:0] ST_H8   = 5'd26;
  localparam logic [4:0] ST_OUT  = 5'd27;

  function automatic logic [63:0] sx16(logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

  function automatic logic [63:0] sx8(logic [7:0] x);
    return {{56{x[7]}}, x};
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int unsigned s);
    return $unsigned($signed(x) >>> s);
  endfunction

  function automatic logic [31:0] asr32(logic [31:0] x, int unsigned s);
    return $unsigned($signed(x) >>> s);
  endfunction

  logic [4:0]  st_q, st_nxt;
  logic        wait_q, step_done, is_mul, out_valid_q, out_free;
  logic        mul_start, mul_done, div_start, div_done;
  logic [63:0] mul_a, mul_b, mul_res, div_res, m;
  logic [31:0] m32;
  in_item_t    item_q;
  out_item_t   out_q;

  logic [63:0] tf_q, ra_q, rb_q, rv1_q, rv2_q, rsq_q, rnum_q, rp_q;
  logic [31:0] rx_q, ry_q, rhv_q, temp_q, press_q;
  logic [16:0] hum_q;
  logic        inv_q;

  logic [63:0] ta, td, t5, tc, pq, ps, num0;
  logic [20:0] pbase;
  logic [31:0] hx, hv, hcl;

  assign m   = mul_res;
  assign m32 = mul_res[31:0];

  // Arithmetic around the sequencer steps.
  always_comb begin
    ta    = {47'b0, item_q.raw_temperature[19:3]} - {47'b0, coeff_i.t1, 1'b0};
    td    = {48'b0, item_q.raw_temperature[19:4]} - {48'b0, coeff_i.t1};
    t5    = (tf_q << 2) + tf_q + 64'd128;
    tc    = asr64(t5, 8);
    pq    = asr64(rp_q, 13);
    ps    = asr64(rp_q + ra_q + rb_q, 8) + (sx16(coeff_i.p7) << 4);
    pbase = 21'd1048576 - {1'b0, item_q.raw_pressure};
    num0  = ({43'b0, pbase} << 31) - rv2_q;
    hx    = {2'b0, item_q.raw_humidity, 14'b0} - {coeff_i.h4[11:0], 20'b0}
            - m32 + 32'd16384;
    hv    = rhv_q - asr32(m32, 4);
    if (hv[31])                  hcl = '0;
    else if (hv > 32'd419430400) hcl = 32'd419430400;
    else                         hcl = hv;
  end

  // Multiplier operands for each step.
  always_comb begin
    is_mul = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (st_q)
      ST_T0:  begin mul_a = ta;    mul_b = sx16(coeff_i.t2); end
      ST_T1:  begin mul_a = td;    mul_b = td; end
      ST_T2:  begin mul_a = rb_q;  mul_b = sx16(coeff_i.t3); end
      ST_P0:  begin mul_a = rv1_q; mul_b = rv1_q; end
      ST_P1:  begin mul_a = rsq_q; mul_b = sx16(coeff_i.p6); end
      ST_P2:  begin mul_a = rv1_q; mul_b = sx16(coeff_i.p5); end
      ST_P3:  begin mul_a = rsq_q; mul_b = sx16(coeff_i.p3); end
      ST_P4:  begin mul_a = rv1_q; mul_b = sx16(coeff_i.p2); end
      ST_P5:  begin mul_a = ra_q + (64'd1 << 47); mul_b = {48'b0, coeff_i.p1}; end
      ST_P7:  begin mul_a = rnum_q; mul_b = 64'd3125; end
      ST_P9:  begin mul_a = sx16(coeff_i.p9); mul_b = pq; end
      ST_P10: begin mul_a = ra_q;  mul_b = pq; end
      ST_P11: begin mul_a = sx16(coeff_i.p8); mul_b = rp_q; end
      ST_H1:  begin mul_a = {32'b0, rhv_q}; mul_b = sx16(coeff_i.h5); end
      ST_H2:  begin mul_a = {32'b0, rhv_q}; mul_b = sx8(coeff_i.h6); end
      ST_H3:  begin mul_a = {32'b0, rhv_q}; mul_b = {56'b0, coeff_i.h3}; end
      ST_H4:  begin mul_a = ra_q;  mul_b = rb_q; end
      ST_H5:  begin mul_a = {32'b0, ry_q}; mul_b = sx16(coeff_i.h2); end
      ST_H6:  begin mul_a = {32'b0, rx_q}; mul_b = {32'b0, ry_q}; end
      ST_H7:  begin mul_a = rb_q;  mul_b = rb_q; end
      ST_H8:  begin mul_a = ra_q;  mul_b = {56'b0, coeff_i.h1}; end
      default: is_mul = 1'b0;
    endcase
  end

  assign mul_start = is_mul && !wait_q;
  assign div_start = (st_q == ST_P8) && !wait_q;
  assign out_free  = !out_valid_q || out_ready_i;
  assign q_ready_o = (st_q == ST_IDLE);

  // Step completion and sequencing.
  always_comb begin
    if (is_mul)                  step_done = wait_q && mul_done;
    else if (st_q == ST_P8)      step_done = wait_q && div_done;
    else if (st_q == ST_IDLE)    step_done = q_valid_i;
    else if (st_q == ST_OUT)     step_done = out_free;
    else                         step_done = 1'b1;
    if (st_q == ST_OUT)                          st_nxt = ST_IDLE;
    else if (st_q == ST_P6 && rv1_q == 64'd0)    st_nxt = ST_H0;
    else                                         st_nxt = st_q + 5'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      wait_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (mul_start || div_start) wait_q <= 1'b1;
      else if (step_done)         wait_q <= 1'b0;
      if (step_done) st_q <= st_nxt;
      if (st_q == ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i)           out_valid_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (step_done) begin
      case (st_q)
        ST_IDLE: item_q <= q_data_i;
        ST_T0:   ra_q   <= asr64(m, 11);
        ST_T1:   rb_q   <= asr64(m, 12);
        ST_T2:   tf_q   <= ra_q + asr64(m, 14);
        ST_T3: begin
          temp_q <= tc[31:0];
          rv1_q  <= tf_q - 64'd128000;
        end
        ST_P0:   rsq_q  <= m;
        ST_P1:   rv2_q  <= m;
        ST_P2:   rv2_q  <= rv2_q + (m << 17);
        ST_P3:   ra_q   <= asr64(m, 8);
        ST_P4: begin
          ra_q  <= ra_q + (m << 12);
          rv2_q <= rv2_q + (sx16(coeff_i.p4) << 35);
        end
        ST_P5:   rv1_q  <= asr64(m, 33);
        ST_P6: begin
          inv_q   <= (rv1_q == 64'd0);
          press_q <= '0;
          rnum_q  <= num0;
        end
        ST_P7:   rnum_q <= m;
        ST_P8:   rp_q   <= div_res;
        ST_P9:   ra_q   <= m;
        ST_P10:  ra_q   <= asr64(m, 25);
        ST_P11:  rb_q   <= asr64(m, 19);
        ST_P12: begin
          if (ps[63])              press_q <= '0;
          else if (|ps[63:32])     press_q <= 32'hFFFF_FFFF;
          else                     press_q <= ps[31:0];
        end
        ST_H0:   rhv_q  <= tf_q[31:0] - 32'd76800;
        ST_H1:   rx_q   <= asr32(hx, 15);
        ST_H2:   ra_q   <= {32'b0, asr32(m32, 10)};
        ST_H3:   rb_q   <= {32'b0, asr32(m32, 11) + 32'd32768};
        ST_H4:   ry_q   <= asr32(m32, 10) + 32'd2097152;
        ST_H5:   ry_q   <= asr32(m32 + 32'd8192, 14);
        ST_H6: begin
          rhv_q <= m32;
          rb_q  <= {32'b0, asr32(m32, 15)};
        end
        ST_H7:   ra_q   <= {32'b0, asr32(m32, 7)};
        ST_H8:   hum_q  <= hcl[28:12];
        ST_OUT: begin
          out_q.temperature_centi <= $signed(temp_q);
          out_q.pressure_q24_8    <= press_q;
          out_q.humidity_q22_10   <= hum_q;
          out_q.pressure_invalid  <= inv_q;
        end
        default: ;
      endcase
    end
  end

  esc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  esc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (rnum_q),
    .den_i   (rv1_q),
    .done_o  (div_done),
    .quo_o   (div_res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A multiplier result only arrives for a step that is waiting on it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> wait_q && is_mul)
    else $error("multiplier result with no waiting step");

  // The divider only finishes during the division step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> st_q == ST_P8 && wait_q)
    else $error("divider result outside the division step");

endmodule

@@ design/env_sensor_compensation_top.sv @@
// ----------------------------------------------------------------------------
// Environmental sensor compensation, top level
// Compensates raw temperature, pressure and humidity readings.
// ----------------------------------------------------------------------------
// The back end's step sequencer runs up to 21 multiplies on one shared
// 32 x 32 multiplier and a 64-bit divider that produces one quotient bit per
// cycle; the division is skipped when the pressure divisor is zero. A
// two-entry queue in front accepts new items while one is being computed,
// and the result register holds a finished item until it is taken.
// Temperature is in 0.01 degC, pressure in Pa/256 and humidity in %RH/1024;
// pressure_invalid flags a zero divisor. Coefficient registers are to be
// written only while no item is in flight; the block does not enforce this.
module env_sensor_compensation_top
  import esc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o
);

  logic     q_valid, q_ready;
  in_item_t q_data;
  coeff_t   coeff;

  esc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_valid_o   (q_valid),
    .q_ready_i   (q_ready),
    .q_data_o    (q_data),
    .coeff_o     (coeff)
  );

  esc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_data_i    (q_data),
    .coeff_i     (coeff),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Environmental sensor compensation testbench
// Writes calibration sets through the configuration port and sends raw
// readings with random gaps on both sides. A directed table comes first, then
// random readings. Every result is checked field by field against a fixed
// expected value or a bit-exact predictor of the integer compensation.
// ----------------------------------------------------------------------------
module tb
  import esc_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // Index with no register behind it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned SETTLE_CYCLES = 400;

  // One row of the directed table.
  typedef struct {
    in_item_t  item;
    bit        known;
    out_item_t want;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_data_o;

  logic [47:0] coeff_regs [6];
  out_item_t   expected_results [$];
  int          error_count = 0;
  bit          no_gaps = 1'b0;

  env_sensor_compensation_top dut (.*);

  // Free-running clock.
  always #5 clk_i = ~clk_i;

  // Hard limit on the run.
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // Prints one mismatch line and counts it.
  task automatic report(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic int draw_gap();
    return no_gaps ? 0 : int'($urandom_range(0, 17));
  endfunction

  // Signed 64-bit division truncating toward zero, wrapping on overflow.
  function automatic longint div_trunc(longint a, longint b);
    bit [63:0] ma, mb, q;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    q = ma / mb;
    return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // Compensates one raw reading with the current coefficients.
  function automatic out_item_t compensate(in_item_t r);
    out_item_t res;
    longint t1, t2, t3, adc_t, a, d, t_fine;
    longint p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, q, w1, w2;
    int h1, h2, h3, h4, h5, h6, hv, x, y, s;
    res = '0;
    // Temperature path, exact with floor shifts.
    t1 = longint'({48'b0, coeff_regs[CFG_TEMP][15:0]});
    t2 = longint'($signed(coeff_regs[CFG_TEMP][31:16]));
    t3 = longint'($signed(coeff_regs[CFG_TEMP][47:32]));
    adc_t = longint'({44'b0, r.raw_temperature});
    a = (adc_t >>> 3) - (t1 <<< 1);
    d = (adc_t >>> 4) - t1;
    t_fine = ((a * t2) >>> 11) + ((((d * d) >>> 12) * t3) >>> 14);
    res.temperature_centi = 32'((t_fine * 5 + 128) >>> 8);

    // Pressure path, 64-bit wrapping.
    p1 = longint'({48'b0, coeff_regs[CFG_PRESS_A][15:0]});
    p2 = longint'($signed(coeff_regs[CFG_PRESS_A][31:16]));
    p3 = longint'($signed(coeff_regs[CFG_PRESS_A][47:32]));
    p4 = longint'($signed(coeff_regs[CFG_PRESS_B][15:0]));
    p5 = longint'($signed(coeff_regs[CFG_PRESS_B][31:16]));
    p6 = longint'($signed(coeff_regs[CFG_PRESS_B][47:32]));
    p7 = longint'($signed(coeff_regs[CFG_PRESS_C][15:0]));
    p8 = longint'($signed(coeff_regs[CFG_PRESS_C][31:16]));
    p9 = longint'($signed(coeff_regs[CFG_PRESS_C][47:32]));
    v1 = t_fine - 128000;
    v2 = v1 * v1 * p6;
    v2 += (v1 * p5) <<< 17;
    v2 += p4 <<< 35;
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((longint'(1) <<< 47) + v1) * p1) >>> 33;
    if (v1 == 0) begin
      res.pressure_invalid = 1'b1;
    end else begin
      p = 1048576 - longint'({44'b0, r.raw_pressure});
      p = div_trunc(((p <<< 31) - v2) * 3125, v1);
      q = p >>> 13;
      w1 = (p9 * q * q) >>> 25;
      w2 = (p8 * p) >>> 19;
      p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
      if (p < 0) res.pressure_q24_8 = '0;
      else if (p > 64'hFFFF_FFFF) res.pressure_q24_8 = '1;
      else res.pressure_q24_8 = p[31:0];
    end

    // Humidity path, 32-bit wrapping.
    h1 = int'({24'b0, coeff_regs[CFG_HUM_A][7:0]});
    h2 = int'($signed(coeff_regs[CFG_HUM_A][23:8]));
    h3 = int'({24'b0, coeff_regs[CFG_HUM_A][31:24]});
    h4 = int'($signed(coeff_regs[CFG_HUM_B][15:0]));
    h5 = int'($signed(coeff_regs[CFG_HUM_B][31:16]));
    h6 = int'($signed(coeff_regs[CFG_HUM_B][39:32]));
    hv = int'(t_fine) - 76800;
    x = (int'({16'b0, r.raw_humidity}) <<< 14) - (h4 <<< 20) - h5 * hv + 16384;
    x = x >>> 15;
    y = ((hv * h6) >>> 10) * (((hv * h3) >>> 11) + 32768);
    y = (y >>> 10) + 2097152;
    y = (y * h2 + 8192) >>> 14;
    hv = x * y;
    s = hv >>> 15;
    hv = hv - ((((s * s) >>> 7) * h1) >>> 4);
    if (hv < 0) hv = 0;
    if (hv > 419430400) hv = 419430400;
    res.humidity_q22_10 = 17'(hv >>> 12);
    return res;
  endfunction

  // Writes one register, mirroring it in the predictor.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_TEMP, CFG_PRESS_A, CFG_PRESS_B, CFG_PRESS_C: coeff_regs[idx] = data;
      CFG_HUM_A: coeff_regs[idx] = {16'b0, data[31:0]};
      CFG_HUM_B: coeff_regs[idx] = {8'b0, data[39:0]};
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic cfg_write_all(logic [CFG_DATA_W-1:0] vals [6]);
    for (int i = 0; i < 6; i++) cfg_write(CFG_IDX_W'(i), vals[i]);
  endtask

  // Sends one reading after a random gap and records what it must produce.
  task automatic send_item(in_item_t item, bit known, out_item_t want);
    int gap;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = item;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(known ? want : compensate(item));
  endtask

  // Lets the block drain before touching the registers again.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    it.raw_temperature = 20'($urandom);
    it.raw_pressure = 20'($urandom);
    it.raw_humidity = 16'($urandom);
    // Mostly plausible readings, the rest anywhere in range.
    if ($urandom_range(0, 3) != 0) begin
      it.raw_temperature = 20'($urandom_range(400000, 600000));
      it.raw_pressure = 20'($urandom_range(250000, 450000));
      it.raw_humidity = 16'($urandom_range(15000, 40000));
    end
    return it;
  endfunction

  // Result side: random stalls, then check against the oldest expectation.
  initial begin
    int stall;
    forever begin
      stall = draw_gap();
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o));
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.temperature_centi !== want.temperature_centi)
          report("temperature_centi", out_data_o.temperature_centi, want.temperature_centi);
        if (out_data_o.pressure_q24_8 !== want.pressure_q24_8)
          report("pressure_q24_8", out_data_o.pressure_q24_8, want.pressure_q24_8);
        if (out_data_o.humidity_q22_10 !== want.humidity_q22_10)
          report("humidity_q22_10", out_data_o.humidity_q22_10, want.humidity_q22_10);
        if (out_data_o.pressure_invalid !== want.pressure_invalid)
          report("pressure_invalid", out_data_o.pressure_invalid, want.pressure_invalid);
      end
    end
  end

  // Main sequence.
  initial begin
    stim_row_t table_rows [$];
    logic [CFG_DATA_W-1:0] typical [6];
    logic [CFG_DATA_W-1:0] extreme [6];
    logic [CFG_DATA_W-1:0] rand_set [6];
    out_item_t zero_coeff_result;
    out_item_t none;

    for (int i = 0; i < 6; i++) coeff_regs[i] = '0;
    none = '0;
    zero_coeff_result = '0;
    zero_coeff_result.pressure_invalid = 1'b1;

    // A typical calibration set: T1..T3, P1..P9, H1..H6.
    typical[0] = {16'hFC18, 16'd26435, 16'd27504};
    typical[1] = {16'd3024, 16'hD643, 16'd36477};
    typical[2] = {16'hFFF9, 16'd140, 16'd2855};
    typical[3] = {16'd6000, 16'hC6F8, 16'd15500};
    typical[4] = {16'b0, 8'd0, 16'd362, 8'd75};
    typical[5] = {8'b0, 8'd30, 16'd50, 16'd313};
    for (int i = 0; i < 6; i++) extreme[i] = '1;

    // After reset all coefficients are zero: the divisor is zero, everything else 0.
    table_rows.push_back('{'{20'd0, 20'd0, 16'd0}, 1'b1, zero_coeff_result});
    table_rows.push_back('{'{20'hFFFFF, 20'hFFFFF, 16'hFFFF}, 1'b1, zero_coeff_result});
    table_rows.push_back('{'{20'hAAAAA, 20'h55555, 16'hAAAA}, 1'b1, zero_coeff_result});
    table_rows.push_back('{'{20'h55555, 20'hAAAAA, 16'h5555}, 1'b1, zero_coeff_result});

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (table_rows[i]) send_item(table_rows[i].item, table_rows[i].known, table_rows[i].want);
    wait_idle();

    // Typical calibration: extremes of the readings and the humidity clamps.
    cfg_write_all(typical);
    cfg_write(CFG_UNMAPPED, '1);
    table_rows.delete();
    table_rows.push_back('{'{20'd519888, 20'd415148, 16'd27000}, 1'b0, none});
    table_rows.push_back('{'{20'd0, 20'd0, 16'd0}, 1'b0, none});
    table_rows.push_back('{'{20'hFFFFF, 20'hFFFFF, 16'hFFFF}, 1'b0, none});
    table_rows.push_back('{'{20'd519888, 20'd0, 16'd0}, 1'b0, none});
    table_rows.push_back('{'{20'd519888, 20'hFFFFF, 16'hFFFF}, 1'b0, none});
    table_rows.push_back('{'{20'hFFFFF, 20'd300000, 16'd0}, 1'b0, none});
    table_rows.push_back('{'{20'd0, 20'd300000, 16'hFFFF}, 1'b0, none});
    table_rows.push_back('{'{20'd1, 20'd1, 16'd1}, 1'b0, none});
    foreach (table_rows[i]) send_item(table_rows[i].item, 1'b0, none);
    wait_idle();

    // Every coefficient at its all-ones extreme.
    cfg_write_all(extreme);
    foreach (table_rows[i]) send_item(table_rows[i].item, 1'b0, none);
    wait_idle();

    // Random phases: typical, fully random and near-typical calibrations.
    for (int ph = 0; ph < 6; ph++) begin
      no_gaps = (ph == 2);
      for (int i = 0; i < 6; i++) begin
        case (ph % 3)
          0: rand_set[i] = typical[i];
          1: rand_set[i] = CFG_DATA_W'({$urandom, $urandom});
          default: rand_set[i] = typical[i] ^ CFG_DATA_W'($urandom_range(0, 255));
        endcase
      end
      cfg_write_all(rand_set);
      for (int n = 0; n < RANDOM_ITEMS / 6; n++) send_item(random_item(), 1'b0, none);
      wait_idle();
    end

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/esc_pkg.sv
design/esc_fifo.sv
design/esc_front.sv
design/esc_mul.sv
design/esc_div.sv
design/esc_back.sv
design/env_sensor_compensation_top.sv
dv/tb.sv
